// ----- hw/rtl/quoted_csv_entity_decoder_top_assert.svh -----
// Assertion macros for the quoted field decoder. Each expects clk_i and rst_ni in scope.
`ifndef QUOTED_CSV_ENTITY_DECODER_TOP_ASSERT_SVH
`define QUOTED_CSV_ENTITY_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QCED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/qced_pkg.sv -----
`default_nettype none

package qced_pkg;

  localparam int MaxResults       = 8;
  localparam int ResIdxW          = $clog2(MaxResults);
  localparam int HeldMax          = 5;
  localparam int MaxFieldsDefault = 64;
  localparam int FieldIdxW        = 6;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharQuery = 8'h3F;
  localparam logic [7:0] LeadC2    = 8'hC2;
  localparam logic [7:0] LeadC3    = 8'hC3;

  // Number of entity bytes held back so far.
  localparam logic [2:0] HeldNone   = 3'd0;
  localparam logic [2:0] HeldAmp    = 3'd1;
  localparam logic [2:0] HeldHash   = 3'd2;
  localparam logic [2:0] HeldX      = 3'd3;
  localparam logic [2:0] HeldFirst  = 3'd4;
  localparam logic [2:0] HeldSecond = 3'd5;

  localparam logic [3:0] HighCToF [4] = '{4'd8, 4'd9, 4'd10, 4'd11};

  typedef enum logic [4:0] {
    ModeOutside = 5'b00001,
    ModeQuote   = 5'b00010,
    ModeSkip    = 5'b00100,
    ModeField   = 5'b01000,
    ModeEntity  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } res_t;

  // Value of an uppercase hex digit, or 16 for anything else.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'h00;
    if (c >= CharZero && c <= CharNine) begin
      diff = c - CharZero;
      return diff[4:0];
    end
    if (c >= CharUpA && c <= CharUpF) begin
      diff = c - CharUpA + 8'd10;
      return diff[4:0];
    end
    return 5'd16;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/quoted_csv_entity_decoder_top.sv -----
// Quoted field extractor with numeric entity decoding.
// Input channel: one byte of a text line per item (data_byte_i, end_of_line_i), taken
// when in_valid_i and in_ready_o are both high. Output channel: one result item per
// handshake (out_kind_o, out_byte_o, field_index_o, last_of_run_o) under out_valid_o
// and out_ready_i; last_of_run_o marks the final result caused by one input byte.
// An accepted item waits in the input register, then its whole group of
// results (none to seven) is decoded in one pass into the result register, and the
// first result of the item is offered from there.
// Throughput is one item per cycle while each item yields at most one result and no
// stall occurs. An item with several results holds the result register, one result
// per cycle unless stalled, and the input register waits; one with none skips it.
// Reset returns the parser to outside any field, clears the held entity bytes and the
// field count, and empties both registers. When the receiver stalls, the current result
// is held steady, the next item waits in the input register and in_ready_o drops.
`default_nettype none

`include "quoted_csv_entity_decoder_top_assert.svh"

module quoted_csv_entity_decoder_top
  import qced_pkg::*;
#(
  parameter int MAX_FIELDS = MaxFieldsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 end_of_line_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      out_kind_o,
  output logic [7:0]                out_byte_o,
  output logic [FieldIdxW-1:0]      field_index_o,
  output logic                      last_of_run_o
);

  // The field counter saturates at the smaller of MAX_FIELDS - 1 and its own top value.
  localparam int FieldTopInt = ((MAX_FIELDS - 1) < ((1 << FieldIdxW) - 1)) ?
                               (MAX_FIELDS - 1) : ((1 << FieldIdxW) - 1);
  localparam logic [FieldIdxW-1:0] FieldTop = FieldIdxW'(FieldTopInt);

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eol_q;

  // Parser state.
  mode_e                mode_q, mode_d;
  logic [2:0]           held_q, held_d;
  logic [7:0]           fd_q, fd_d;
  logic [7:0]           sd_q, sd_d;
  logic [FieldIdxW-1:0] fc_q, fc_d;

  // Result register: the whole group of results of one item.
  logic                 bst_vld_q;
  res_t                 bst_q [MaxResults];
  logic [ResIdxW-1:0]   bst_ptr_q;
  logic [ResIdxW-1:0]   bst_last_q;
  logic [FieldIdxW-1:0] bst_idx_q;

  // Decoder outputs.
  res_t               res_d [MaxResults];
  logic [ResIdxW-1:0] res_cnt;
  logic               plain;
  logic               do_end;
  logic               flush_ok;
  logic [2:0]         flush_cnt;
  logic [7:0]         held_bytes [HeldMax];
  logic [4:0]         h1;
  logic [4:0]         h2;

  logic out_fire;
  logic bst_free;
  logic adv;

  assign out_fire   = bst_vld_q && out_ready_i;
  assign bst_free   = !bst_vld_q || (out_fire && (bst_ptr_q == bst_last_q));
  assign adv        = in_vld_q && bst_free;
  assign in_ready_o = !in_vld_q || adv;

  assign h1 = hex_val(fd_q);
  assign h2 = hex_val(sd_q);

  always_comb begin
    mode_d    = mode_q;
    held_d    = held_q;
    fd_d      = fd_q;
    sd_d      = sd_q;
    fc_d      = fc_q;
    res_cnt   = '0;
    plain     = 1'b0;
    do_end    = 1'b0;
    flush_ok  = 1'b1;
    flush_cnt = HeldNone;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = '0;
    end
    held_bytes[0] = CharAmp;
    held_bytes[1] = CharHash;
    held_bytes[2] = CharX;
    held_bytes[3] = fd_q;
    held_bytes[4] = sd_q;

    // Main step for the current byte.
    case (mode_q)
      ModeOutside: begin
        if (in_byte_q == CharQuote) begin
          mode_d = ModeQuote;
        end
      end
      ModeQuote: begin
        if (in_byte_q == CharComma) begin
          mode_d = ModeOutside;
        end else if (in_byte_q == CharQuote) begin
          res_d[res_cnt] = '{kind: 1'b0, data: CharZero};
          res_cnt        = res_cnt + 1'b1;
          do_end         = 1'b1;
          mode_d         = ModeSkip;
        end else begin
          plain = 1'b1;
        end
      end
      ModeSkip: begin
        mode_d = ModeOutside;
      end
      ModeField: begin
        plain = 1'b1;
      end
      ModeEntity: begin
        case (held_q)
          HeldAmp:   flush_ok = (in_byte_q == CharHash);
          HeldHash:  flush_ok = (in_byte_q == CharX);
          HeldX: begin
            flush_ok = (in_byte_q != CharQuote) && (in_byte_q != CharAmp);
            if (flush_ok) begin
              fd_d = in_byte_q;
            end
          end
          HeldFirst: begin
            flush_ok = (in_byte_q != CharQuote) && (in_byte_q != CharAmp);
            if (flush_ok) begin
              sd_d = in_byte_q;
            end
          end
          default:   flush_ok = 1'b0;
        endcase
        if (held_q == HeldSecond && in_byte_q == CharSemi) begin
          // Complete entity: decode into one or two bytes.
          held_d = HeldNone;
          mode_d = ModeField;
          if (h1[4] || h2[4]) begin
            res_d[res_cnt] = '{kind: 1'b0, data: CharQuery};
            res_cnt        = res_cnt + 1'b1;
          end else if (h1[3:0] <= 4'd9) begin
            res_d[res_cnt] = '{kind: 1'b0, data: {h1[3:0], h2[3:0]}};
            res_cnt        = res_cnt + 1'b1;
          end else if (h1[3:0] <= 4'd11) begin
            res_d[res_cnt] = '{kind: 1'b0, data: LeadC2};
            res_cnt        = res_cnt + 1'b1;
            res_d[res_cnt] = '{kind: 1'b0, data: {h1[3:0], h2[3:0]}};
            res_cnt        = res_cnt + 1'b1;
          end else begin
            res_d[res_cnt] = '{kind: 1'b0, data: LeadC3};
            res_cnt        = res_cnt + 1'b1;
            res_d[res_cnt] = '{kind: 1'b0, data: {HighCToF[h1[1:0]], h2[3:0]}};
            res_cnt        = res_cnt + 1'b1;
          end
        end else if (flush_ok) begin
          held_d = held_q + 3'd1;
        end else begin
          // Pattern broken: send the held bytes literally, then treat the byte as plain.
          for (int i = 0; i < HeldMax; i++) begin
            if (3'(i) < held_q) begin
              res_d[res_cnt] = '{kind: 1'b0, data: held_bytes[i]};
              res_cnt        = res_cnt + 1'b1;
            end
          end
          held_d = HeldNone;
          plain  = 1'b1;
        end
      end
      default: begin
        mode_d = ModeOutside;
        held_d = HeldNone;
      end
    endcase

    if (plain) begin
      if (in_byte_q == CharQuote) begin
        mode_d = ModeOutside;
        do_end = 1'b1;
      end else if (in_byte_q == CharAmp) begin
        mode_d = ModeEntity;
        held_d = HeldAmp;
      end else begin
        mode_d         = ModeField;
        res_d[res_cnt] = '{kind: 1'b0, data: in_byte_q};
        res_cnt        = res_cnt + 1'b1;
      end
    end

    // Line end: flush what is held and close any open field.
    if (in_eol_q) begin
      if (mode_d == ModeEntity) begin
        flush_cnt = held_d;
      end
      held_bytes[3] = fd_d;
      held_bytes[4] = sd_d;
      for (int i = 0; i < HeldMax; i++) begin
        if (3'(i) < flush_cnt) begin
          res_d[res_cnt] = '{kind: 1'b0, data: held_bytes[i]};
          res_cnt        = res_cnt + 1'b1;
        end
      end
      if (mode_d == ModeField || mode_d == ModeEntity || mode_d == ModeQuote) begin
        do_end = 1'b1;
      end
    end

    // A field end is always the last result of its item.
    if (do_end) begin
      res_d[res_cnt] = '{kind: 1'b1, data: 8'h00};
      res_cnt        = res_cnt + 1'b1;
      if (fc_q < FieldTop) begin
        fc_d = fc_q + 1'b1;
      end
    end

    if (in_eol_q) begin
      mode_d = ModeOutside;
      held_d = HeldNone;
      fd_d   = 8'h00;
      sd_d   = 8'h00;
      fc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      mode_q     <= ModeOutside;
      held_q     <= HeldNone;
      fd_q       <= 8'h00;
      sd_q       <= 8'h00;
      fc_q       <= '0;
      bst_vld_q  <= 1'b0;
      bst_ptr_q  <= '0;
      bst_last_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        mode_q <= mode_d;
        held_q <= held_d;
        fd_q   <= fd_d;
        sd_q   <= sd_d;
        fc_q   <= fc_d;
      end
      if (adv && res_cnt != '0) begin
        bst_vld_q  <= 1'b1;
        bst_ptr_q  <= '0;
        bst_last_q <= res_cnt - 1'b1;
      end else if (out_fire) begin
        if (bst_ptr_q == bst_last_q) begin
          bst_vld_q <= 1'b0;
        end else begin
          bst_ptr_q <= bst_ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_eol_q  <= end_of_line_i;
    end
    if (adv && res_cnt != '0) begin
      bst_q     <= res_d;
      bst_idx_q <= fc_q;
    end
  end

  assign out_valid_o   = bst_vld_q;
  assign out_kind_o    = bst_q[bst_ptr_q].kind;
  assign out_byte_o    = bst_q[bst_ptr_q].data;
  assign field_index_o = bst_idx_q;
  assign last_of_run_o = (bst_ptr_q == bst_last_q);

  `QCED_ASSERT_NOW(a_held_only_in_entity, 1'b1, ((mode_q == ModeEntity) == (held_q != HeldNone)), "held entity bytes outside entity mode")
  `QCED_ASSERT_NOW(a_ptr_in_group, bst_vld_q, (bst_ptr_q <= bst_last_q), "result pointer beyond its group")
  `QCED_ASSERT_NEXT(a_stall_holds_ptr, (bst_vld_q && !out_ready_i), (bst_vld_q && $stable(bst_ptr_q)), "stalled result moved")
  `QCED_ASSERT_NOW(a_field_count_top, 1'b1, (fc_q <= FieldTop), "field count above its ceiling")
  `QCED_ASSERT_NOW(a_not_ready_full, !in_ready_o, (in_vld_q && bst_vld_q), "input blocked without a waiting item")

endmodule

`default_nettype wire

// ----- test/qced_field_checker.sv -----
// Watches both channels of the quoted field decoder, predicts the result items of
// every accepted input item and compares them, in order, with what the block emits.
module qced_field_checker
  import qced_pkg::*;
#(
  parameter int MAX_FIELDS = MaxFieldsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 end_of_line_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic                 out_kind_i,
  input  wire logic [7:0]           out_byte_i,
  input  wire logic [FieldIdxW-1:0] field_index_i,
  input  wire logic                 last_of_run_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam int FieldTop = (MAX_FIELDS - 1) < 63 ? (MAX_FIELDS - 1) : 63;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           data;
    logic [FieldIdxW-1:0] idx;
    logic                 is_last;
  } field_res_t;

  field_res_t           expected_fields[$];
  field_res_t           run_buf[MaxResults];
  int                   run_len;
  int                   fail_total;
  int                   pending_cnt;

  mode_e                mode;
  logic [2:0]           held;
  logic [7:0]           dig1;
  logic [7:0]           dig2;
  logic [FieldIdxW-1:0] field_count;

  assign fail_count_o = fail_total;
  assign pending_o    = pending_cnt;

  task automatic emit(input logic kind, input logic [7:0] data);
    field_res_t r;
    r.kind    = kind;
    r.data    = data;
    r.idx     = field_count;
    r.is_last = 1'b0;
    if (run_len < MaxResults) begin
      run_buf[run_len] = r;
      run_len++;
    end
  endtask

  task automatic close_field();
    emit(1'b1, 8'h00);
    if (int'(field_count) < FieldTop) field_count = field_count + 1'b1;
  endtask

  // Held entity bytes go out as plain text, in the order they came in.
  task automatic flush_held();
    if (held >= HeldAmp) emit(1'b0, CharAmp);
    if (held >= HeldHash) emit(1'b0, CharHash);
    if (held >= HeldX) emit(1'b0, CharX);
    if (held >= HeldFirst) emit(1'b0, dig1);
    if (held >= HeldSecond) emit(1'b0, dig2);
    held = HeldNone;
  endtask

  task automatic field_char(input logic [7:0] c);
    if (c == CharQuote) begin
      mode = ModeOutside;
      close_field();
    end else if (c == CharAmp) begin
      mode = ModeEntity;
      held = HeldAmp;
    end else begin
      mode = ModeField;
      emit(1'b0, c);
    end
  endtask

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
    if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
    return 16;
  endfunction

  task automatic emit_entity();
    int v1;
    int v2;
    int hi;
    v1 = digit_value(dig1);
    v2 = digit_value(dig2);
    if (v1 > 15 || v2 > 15) begin
      emit(1'b0, CharQuery);
    end else if (v1 <= 9) begin
      emit(1'b0, {v1[3:0], v2[3:0]});
    end else if (v1 <= 11) begin
      emit(1'b0, LeadC2);
      emit(1'b0, {v1[3:0], v2[3:0]});
    end else begin
      // Digits C to F map onto 8 to B for the second byte.
      hi = v1 - 4;
      emit(1'b0, LeadC3);
      emit(1'b0, {hi[3:0], v2[3:0]});
    end
  endtask

  task automatic entity_char(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    case (held)
      HeldAmp:  ok = (c == CharHash);
      HeldHash: ok = (c == CharX);
      HeldX: begin
        ok = (c != CharQuote && c != CharAmp);
        if (ok) dig1 = c;
      end
      HeldFirst: begin
        ok = (c != CharQuote && c != CharAmp);
        if (ok) dig2 = c;
      end
      default: ok = 1'b0;
    endcase
    if (held == HeldSecond && c == CharSemi) begin
      held = HeldNone;
      mode = ModeField;
      emit_entity();
    end else if (ok) begin
      held = held + 3'd1;
    end else begin
      flush_held();
      field_char(c);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic eol);
    field_res_t r;
    run_len = 0;
    case (mode)
      ModeOutside: if (c == CharQuote) mode = ModeQuote;
      ModeQuote: begin
        if (c == CharComma) begin
          mode = ModeOutside;
        end else if (c == CharQuote) begin
          emit(1'b0, CharZero);
          close_field();
          mode = ModeSkip;
        end else begin
          field_char(c);
        end
      end
      ModeSkip:   mode = ModeOutside;
      ModeField:  field_char(c);
      ModeEntity: entity_char(c);
      default: begin
        mode = ModeOutside;
        held = HeldNone;
      end
    endcase
    if (eol) begin
      if (mode == ModeEntity) flush_held();
      if (mode == ModeField || mode == ModeEntity || mode == ModeQuote) close_field();
      mode        = ModeOutside;
      held        = HeldNone;
      dig1        = 8'h00;
      dig2        = 8'h00;
      field_count = '0;
    end
    for (int i = 0; i < run_len; i++) begin
      r         = run_buf[i];
      r.is_last = (i == run_len - 1);
      expected_fields.push_back(r);
    end
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (fail_total < 40)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
  endtask

  task automatic check_result();
    field_res_t want;
    logic       bad;
    bad = 1'b0;
    if (expected_fields.size() == 0) begin
      if (fail_total < 40)
        $display("%0t: unexpected result, expected none, got kind %0d byte 0x%0h index %0d",
                 $time, out_kind_i, out_byte_i, field_index_i);
      fail_total++;
    end else begin
      want = expected_fields.pop_front();
      if (out_kind_i !== want.kind) begin
        report_field("out_kind", int'(want.kind), int'(out_kind_i));
        bad = 1'b1;
      end
      if (out_byte_i !== want.data) begin
        report_field("out_byte", int'(want.data), int'(out_byte_i));
        bad = 1'b1;
      end
      if (field_index_i !== want.idx) begin
        report_field("field_index", int'(want.idx), int'(field_index_i));
        bad = 1'b1;
      end
      if (last_of_run_i !== want.is_last) begin
        report_field("last_of_run", int'(want.is_last), int'(last_of_run_i));
        bad = 1'b1;
      end
      if (bad) fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode        = ModeOutside;
      held        = HeldNone;
      dig1        = 8'h00;
      dig2        = 8'h00;
      field_count = '0;
      run_len     = 0;
      fail_total  = 0;
      pending_cnt = 0;
      expected_fields.delete();
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i, end_of_line_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_cnt = expected_fields.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the testbench for the quoted field decoder. It makes the stimulus, paces
// both channels and gives the verdict; all prediction and comparison happens in the
// checker that sits beside the block and watches its ports.
module testbench;
  import qced_pkg::*;

  localparam int FieldLimit = MaxFieldsDefault;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic [7:0]           data_byte = 8'h00;
  logic                 end_of_line = 1'b0;
  logic                 out_ready = 1'b0;
  wire                  in_ready;
  wire                  out_valid;
  wire                  out_kind;
  wire [7:0]            out_byte;
  wire [FieldIdxW-1:0]  field_index;
  wire                  last_of_run;
  int                   fails;
  int                   pending;

  // Percentages that pace the two channels; the phases below change them.
  int                   idle_pct = 0;
  int                   stall_pct = 0;

  // Bytes of the line being built, sent with the line end flag on the last one.
  logic [7:0]           line_buf[$];

  always #1 clk = ~clk;

  quoted_csv_entity_decoder_top #(
    .MAX_FIELDS(FieldLimit)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .end_of_line_i(end_of_line),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .field_index_o(field_index),
    .last_of_run_o(last_of_run)
  );

  qced_field_checker #(
    .MAX_FIELDS(FieldLimit)
  ) checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_byte_i  (data_byte),
    .end_of_line_i(end_of_line),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_kind_i   (out_kind),
    .out_byte_i   (out_byte),
    .field_index_i(field_index),
    .last_of_run_i(last_of_run),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // The receiver decides afresh at every edge whether it will take a result item.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one item and returns at the edge where it is taken. An idle gap, if any,
  // comes first, so that valid is only ever lowered between items and never while an
  // item is on offer.
  task automatic send_byte(input logic [7:0] c, input logic eol);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    data_byte   <= c;
    end_of_line <= eol;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s, input logic eol_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eol_last && (i == s.len() - 1));
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Stops sending until every predicted result item has been taken. The checker's
  // count is read on the falling edge, well clear of its update. Waiting on after
  // that lets an item with no results leave the block as well.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Mostly printable text without quotes or ampersands, sometimes any byte at all.
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    if ($urandom_range(9) < 7) begin
      c = 8'($urandom_range(126, 32));
      if (c == CharQuote || c == CharAmp) c = "z";
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // Mostly an uppercase hex digit, so that all four decode branches are reached.
  function automatic logic [7:0] hex_digit();
    int v;
    logic [7:0] c;
    if ($urandom_range(99) < 85) begin
      v = $urandom_range(15);
      c = 8'((v < 10) ? CharZero + v : CharUpA + v - 10);
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // A byte that may break an entity: a quote, an ampersand, a semicolon or anything.
  function automatic logic [7:0] breaker_byte();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = CharQuote;
      1:       c = CharAmp;
      2:       c = CharSemi;
      default: c = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  // Builds one line: mostly well formed quoted fields whose contents mix plain text,
  // good entities and broken ones, with some noise between fields, empty pairs and
  // quotes followed by a comma. Now and then the line is cut short so that the line
  // end lands in the middle of a field or an entity.
  task automatic build_line();
    int         nf;
    int         ntok;
    int         pick;
    int         stage;
    int         keep;
    line_buf.delete();
    nf = $urandom_range(5, 1);
    for (int f = 0; f < nf; f++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        line_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 16) begin
        line_buf.push_back(CharQuote);
        line_buf.push_back(CharQuote);
        line_buf.push_back(8'($urandom_range(255)));
      end else if (pick < 21) begin
        line_buf.push_back(CharQuote);
        line_buf.push_back(CharComma);
      end else begin
        line_buf.push_back(CharQuote);
        ntok = $urandom_range(6);
        for (int t = 0; t < ntok; t++) begin
          pick = $urandom_range(99);
          if (pick < 55) begin
            line_buf.push_back(text_byte());
          end else if (pick < 80) begin
            line_buf.push_back(CharAmp);
            line_buf.push_back(CharHash);
            line_buf.push_back(CharX);
            line_buf.push_back(hex_digit());
            line_buf.push_back(hex_digit());
            line_buf.push_back(CharSemi);
          end else begin
            stage = $urandom_range(5, 1);
            line_buf.push_back(CharAmp);
            if (stage >= 2) line_buf.push_back(CharHash);
            if (stage >= 3) line_buf.push_back(CharX);
            if (stage >= 4) line_buf.push_back(hex_digit());
            if (stage >= 5) line_buf.push_back(hex_digit());
            line_buf.push_back(breaker_byte());
          end
        end
        if ($urandom_range(9) != 0) line_buf.push_back(CharQuote);
        if ($urandom_range(1) != 0) line_buf.push_back(CharComma);
      end
    end
    if ($urandom_range(4) == 0 && line_buf.size() > 1) begin
      keep = $urandom_range(line_buf.size(), 1);
      while (line_buf.size() > keep) void'(line_buf.pop_back());
    end
  endtask

  // One line with more empty fields than the field index can count, so that the
  // index has to saturate at its top value. Each empty pair skips the byte after it.
  task automatic build_long_line();
    line_buf.delete();
    for (int i = 0; i < FieldLimit + 4; i++) begin
      line_buf.push_back(CharQuote);
      line_buf.push_back(CharQuote);
      line_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int target,
                           input logic with_long);
    int sent;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    if (with_long) begin
      build_long_line();
      send_line();
      sent += line_buf.size();
    end
    while (sent < target) begin
      build_line();
      send_line();
      sent += line_buf.size();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items, with no idling: entities for the two-byte branches, a quote in
    // a digit slot, an empty pair and its skipped byte, a quote followed by a comma,
    // the line end on a pending skip, a quote on the last byte of a line, and a line
    // end with entity bytes still held, with bytes zero and 255 in the field.
    send_text("\"&#xE9;&#xB5;&#x\"\"\"Q\",", 1'b0);
    send_text("\"\"", 1'b1);
    send_text("\"", 1'b1);
    send_byte(CharQuote, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("&#", 1'b1);
    drain();

    // Random lines under each pacing in turn; every phase ends with a full drain.
    run_phase(0, 0, 55, 1'b0);
    run_phase(46, 0, 55, 1'b0);
    run_phase(0, 46, 260, 1'b1);
    run_phase(11, 11, 55, 1'b0);

    @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("** quoted_csv_entity_decoder_top: PASSED **");
    end else begin
      $display("** quoted_csv_entity_decoder_top: FAILED **");
    end
    $finish;
  end

  // A hang anywhere, such as a result item that never arrives, ends the run here.
  initial begin
    #1000000;
    $display("** quoted_csv_entity_decoder_top: FAILED **");
    $finish;
  end

endmodule
